// ----- rtl/tsp_rwg_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_rwg_pkg
// shared types, codes and widths of the ring weight generator
// ----------------------------------------------------------------------------
package tsp_rwg_pkg;

    localparam int MAX_CITIES_DEF = 16;
    localparam int DIST_BITS_DEF  = 16;

    localparam int KIND_W     = 2;
    localparam int CITY_IN_W  = 4;
    localparam int DIST_IN_W  = 16;
    localparam int NEURON_W   = 8;
    localparam int WEIGHT_W   = 16;
    localparam int CLASS_W    = 3;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CITY_CNT_W = 5;
    localparam int STEP_W     = 6;

    localparam int S_TDATA_W = 2 * CITY_IN_W + DIST_IN_W + 2 * NEURON_W;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = WEIGHT_W;
    localparam int M_TUSER_W = CLASS_W + 1;

    localparam int TENTH_Q12      = 410;
    localparam int WEIGHT_MAX_Q12 = 40960;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CLASS_W-1:0] CLS_SAME_NEURON    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_SAME_POS       = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_ADJ_SAME_CITY  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_ADJ_OTHER_CITY = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_DISTANT_SAME   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_NONE           = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAME_POS_W = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADJ_SAME_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_SAME_W = 2'd3;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [CFG_W-1:0] w);
        logic [WEIGHT_W-1:0] r;
        if (w[CFG_W-1]) begin
            r = '0;
        end else if (w > CFG_W'(WEIGHT_MAX_Q12)) begin
            r = WEIGHT_W'(WEIGHT_MAX_Q12);
        end else begin
            r = w[WEIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/tsp_rwg_divider.sv -----
// ----------------------------------------------------------------------------
// tsp_rwg_divider
// shared restoring divider, one quotient bit per cycle, msb-aligned numerator
// ----------------------------------------------------------------------------
module tsp_rwg_divider #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tsp_rwg_pkg::div_req_t req,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output tsp_rwg_pkg::div_sts_t sts,
    output logic [NUM_W-1:0]      quo,
    output logic [DEN_W-1:0]      rem
);
    import tsp_rwg_pkg::*;

    logic [NUM_W-1:0]  num_reg, num_next, quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next, den_reg, den_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]    trial, trial_sub;

    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial_sub[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;
    assign rem      = rem_reg;

endmodule

// ----- rtl/tsp_rwg_distance_ram.sv -----
// ----------------------------------------------------------------------------
// tsp_rwg_distance_ram
// city-to-city distance store, one write and one registered read port
// ----------------------------------------------------------------------------
module tsp_rwg_distance_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tsp_ring_weight_generator.sv -----
// ----------------------------------------------------------------------------
// tsp_ring_weight_generator: load and clear stay in idle, so ready stays high
// query: two 8-step index divides, classify, output; ready again as the result turns valid
// out-of-range index: no divides, straight to the output step; a stalled result holds it
// adjacent different-city query: distance read and a third, weight divide; none at max 0
// sync active-low reset: idle, max distance 0, city count 16, weights 0
// ----------------------------------------------------------------------------
module tsp_ring_weight_generator #(
    parameter int MAX_CITIES = tsp_rwg_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = tsp_rwg_pkg::DIST_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // from_city, to_city, distance, first_neuron, second_neuron
    input  logic [tsp_rwg_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [tsp_rwg_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // weight
    output logic [tsp_rwg_pkg::M_TDATA_W-1:0] m_tdata,
    // link_class, index_error
    output logic [tsp_rwg_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                              cfg_we,
    input  logic [tsp_rwg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsp_rwg_pkg::CFG_W-1:0]     cfg_wdata
);
    import tsp_rwg_pkg::*;

    localparam int CITY_W  = $clog2(MAX_CITIES);
    localparam int CNT_W   = $clog2(MAX_CITIES + 1);
    localparam int NSQ_W   = 2 * CNT_W;
    localparam int CMP_W   = (NSQ_W > NEURON_W) ? NSQ_W : NEURON_W;
    localparam int DEPTH   = MAX_CITIES * MAX_CITIES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TENTH_W = $clog2(TENTH_Q12 + 1);
    localparam int NUM_W   = DIST_BITS + TENTH_W;
    localparam int LD_W    = (DIST_BITS < DIST_IN_W) ? DIST_BITS : DIST_IN_W;
    localparam logic [STEP_W-1:0] NEURON_STEPS = STEP_W'(NEURON_W);
    localparam logic [STEP_W-1:0] WEIGHT_STEPS = STEP_W'(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV_A, ST_DIV_B, ST_CLASSIFY, ST_READ, ST_SCALE, ST_DIV_W, ST_OUT
    } state_t;

    function automatic logic [CITY_IN_W-1:0] wrap_city(input logic [CITY_IN_W-1:0] v);
        logic [CITY_IN_W-1:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (int'(r) >= MAX_CITIES) begin
                r = CITY_IN_W'(int'(r) - MAX_CITIES);
            end
        end
        return r;
    endfunction

    logic [KIND_W-1:0]    s_kind;
    logic [CITY_IN_W-1:0] s_from, s_to;
    logic [DIST_IN_W-1:0] s_distance;
    logic [NEURON_W-1:0]  s_first, s_second;
    logic                 s_fire;

    logic [CITY_CNT_W-1:0] city_count_reg;
    logic [CFG_W-1:0]      same_pos_w_reg, adj_same_w_reg, dist_same_w_reg;

    state_t               state_reg, state_next;
    logic [DIST_BITS-1:0] max_reg, max_next, diff_reg, diff_next;
    logic [NEURON_W-1:0]  b_reg, b_next;
    logic [CITY_W-1:0]    pa_reg, pa_next, ca_reg, ca_next;
    logic [CITY_W-1:0]    pb_reg, pb_next, cb_reg, cb_next;
    logic [WEIGHT_W-1:0]  res_weight_reg, res_weight_next;
    logic [CLASS_W-1:0]   res_class_reg, res_class_next;
    logic                 res_err_reg, res_err_next;
    logic                 m_valid_reg, m_valid_next;
    logic [WEIGHT_W-1:0]  m_weight_reg, m_weight_next;
    logic [CLASS_W-1:0]   m_class_reg, m_class_next;
    logic                 m_err_reg, m_err_next;

    logic [CNT_W-1:0]     active;
    logic [NSQ_W-1:0]     nsq;
    logic                 idx_err;
    logic [DIST_BITS-1:0] load_dist;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [DIST_BITS-1:0] ram_rdata;
    logic [CITY_W-1:0]    gap;
    logic                 same_city, adjacent;

    div_req_t             div_req;
    div_sts_t             div_sts;
    logic [NUM_W-1:0]     div_num, div_quo;
    logic [DIST_BITS-1:0] div_den, div_rem;

    assign s_kind     = s_tuser;
    assign s_from     = s_tdata[CITY_IN_W-1:0];
    assign s_to       = s_tdata[2*CITY_IN_W-1:CITY_IN_W];
    assign s_distance = s_tdata[2*CITY_IN_W+DIST_IN_W-1:2*CITY_IN_W];
    assign s_first    = s_tdata[2*CITY_IN_W+DIST_IN_W+NEURON_W-1:2*CITY_IN_W+DIST_IN_W];
    assign s_second   = s_tdata[S_TDATA_W-1:S_TDATA_W-NEURON_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg  <= CITY_CNT_W'(16);
            same_pos_w_reg  <= '0;
            adj_same_w_reg  <= '0;
            dist_same_w_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CITY_COUNT:  city_count_reg  <= cfg_wdata[CITY_CNT_W-1:0];
                REG_SAME_POS_W:  same_pos_w_reg  <= cfg_wdata;
                REG_ADJ_SAME_W:  adj_same_w_reg  <= cfg_wdata;
                REG_DIST_SAME_W: dist_same_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (city_count_reg < CITY_CNT_W'(2)) begin
            active = CNT_W'(2);
        end else if (int'(city_count_reg) > MAX_CITIES) begin
            active = CNT_W'(MAX_CITIES);
        end else begin
            active = CNT_W'(city_count_reg);
        end
    end

    assign nsq     = NSQ_W'(active) * NSQ_W'(active);
    assign idx_err = (CMP_W'(s_first) >= CMP_W'(nsq)) || (CMP_W'(s_second) >= CMP_W'(nsq));

    assign load_dist = DIST_BITS'(s_distance[LD_W-1:0]);
    assign ram_we    = s_fire && (s_kind == KIND_LOAD);
    assign ram_waddr = ADDR_W'(int'(wrap_city(s_from)) * MAX_CITIES + int'(wrap_city(s_to)));
    assign ram_raddr = ADDR_W'(int'(ca_reg) * MAX_CITIES + int'(cb_reg));

    tsp_rwg_distance_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DIST_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (load_dist),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = NEURON_STEPS;
        div_num       = {s_first, {(NUM_W-NEURON_W){1'b0}}};
        div_den       = DIST_BITS'(active);
        case (state_reg)
            ST_IDLE: begin
                div_req.start = s_fire && (s_kind == KIND_QUERY) && !idx_err;
            end
            ST_DIV_A: begin
                div_req.start = div_sts.done;
                div_num       = {b_reg, {(NUM_W-NEURON_W){1'b0}}};
            end
            ST_SCALE: begin
                div_req.start = 1'b1;
                div_req.steps = WEIGHT_STEPS;
                div_num       = NUM_W'(diff_reg) * NUM_W'(TENTH_Q12);
                div_den       = max_reg;
            end
            default: ;
        endcase
    end

    tsp_rwg_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DIST_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .den     (div_den),
        .sts     (div_sts),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign gap       = (pa_reg > pb_reg) ? (pa_reg - pb_reg) : (pb_reg - pa_reg);
    assign same_city = (ca_reg == cb_reg);
    assign adjacent  = (gap == CITY_W'(1)) || (CNT_W'(gap) == (active - CNT_W'(1)));

    always_comb begin
        state_next      = state_reg;
        max_next        = max_reg;
        diff_next       = diff_reg;
        b_next          = b_reg;
        pa_next         = pa_reg;
        ca_next         = ca_reg;
        pb_next         = pb_reg;
        cb_next         = cb_reg;
        res_weight_next = res_weight_reg;
        res_class_next  = res_class_reg;
        res_err_next    = res_err_reg;
        m_valid_next    = m_valid_reg;
        m_weight_next   = m_weight_reg;
        m_class_next    = m_class_reg;
        m_err_next      = m_err_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_kind)
                        KIND_LOAD: begin
                            if (load_dist > max_reg) begin
                                max_next = load_dist;
                            end
                        end
                        KIND_CLEAR: begin
                            max_next = '0;
                        end
                        KIND_QUERY: begin
                            b_next = s_second;
                            if (idx_err) begin
                                res_weight_next = '0;
                                res_class_next  = CLS_NONE;
                                res_err_next    = 1'b1;
                                state_next      = ST_OUT;
                            end else begin
                                res_err_next = 1'b0;
                                state_next   = ST_DIV_A;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_A: begin
                if (div_sts.done) begin
                    pa_next    = div_quo[CITY_W-1:0];
                    ca_next    = div_rem[CITY_W-1:0];
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_sts.done) begin
                    pb_next    = div_quo[CITY_W-1:0];
                    cb_next    = div_rem[CITY_W-1:0];
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                state_next = ST_OUT;
                if (gap == '0) begin
                    if (same_city) begin
                        res_class_next  = CLS_SAME_NEURON;
                        res_weight_next = '0;
                    end else begin
                        res_class_next  = CLS_SAME_POS;
                        res_weight_next = clamp_weight(same_pos_w_reg);
                    end
                end else if (adjacent) begin
                    if (same_city) begin
                        res_class_next  = CLS_ADJ_SAME_CITY;
                        res_weight_next = clamp_weight(adj_same_w_reg);
                    end else begin
                        res_class_next = CLS_ADJ_OTHER_CITY;
                        state_next     = ST_READ;
                    end
                end else begin
                    if (same_city) begin
                        res_class_next  = CLS_DISTANT_SAME;
                        res_weight_next = clamp_weight(dist_same_w_reg);
                    end else begin
                        res_class_next  = CLS_NONE;
                        res_weight_next = '0;
                    end
                end
            end
            ST_READ: begin
                if (max_reg == '0) begin
                    res_weight_next = WEIGHT_W'(2 * TENTH_Q12);
                    state_next      = ST_OUT;
                end else begin
                    diff_next  = (ram_rdata >= max_reg) ? '0 : (max_reg - ram_rdata);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_DIV_W;
            end
            ST_DIV_W: begin
                if (div_sts.done) begin
                    res_weight_next = WEIGHT_W'(TENTH_Q12) + div_quo[WEIGHT_W-1:0];
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_weight_next = res_weight_reg;
                    m_class_next  = res_class_reg;
                    m_err_next    = res_err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            max_reg        <= max_next;
            m_valid_reg    <= m_valid_next;
            diff_reg       <= diff_next;
            b_reg          <= b_next;
            pa_reg         <= pa_next;
            ca_reg         <= ca_next;
            pb_reg         <= pb_next;
            cb_reg         <= cb_next;
            res_weight_reg <= res_weight_next;
            res_class_reg  <= res_class_next;
            res_err_reg    <= res_err_next;
            m_weight_reg   <= m_weight_next;
            m_class_reg    <= m_class_next;
            m_err_reg      <= m_err_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_weight_reg;
    assign m_tuser  = {m_err_reg, m_class_reg};

`ifndef NO_ASSERTIONS
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[CLASS_W]) |-> (m_tdata == '0 && m_tuser[CLASS_W-1:0] == CLS_NONE))
        else $error("index error transaction without zero weight and no-link class");

    a_scaled_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[CLASS_W-1:0] == CLS_ADJ_OTHER_CITY)
        |-> (m_tdata >= M_TDATA_W'(TENTH_Q12) && m_tdata <= M_TDATA_W'(2 * TENTH_Q12)))
        else $error("distance weight outside tenth to two tenths");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> (state_reg == ST_DIV_A || state_reg == ST_DIV_B || state_reg == ST_DIV_W))
        else $error("divider finished outside a divide step");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_QUERY) |=> !s_tready)
        else $error("ready right after a query transaction");
`endif

endmodule
